// ----- rtl/core/mvmix_pkg.sv -----
// shared types, widths and constants of the multivoice mixer
package mvmix_pkg;

   // payload widths
   localparam int SampleWidth = 16;
   localparam int LevelWidth  = 8;
   localparam int VolWidth    = 9;
   localparam int RawWidth    = 24;
   localparam int AccWidth    = 32;
   localparam int OutWidth    = 16;
   localparam int ByteWidth   = 8;
   localparam int PosWidth    = 14;

   // shared multiplier operand and product widths
   localparam int MulAWidth   = SampleWidth + 1;
   localparam int MulBWidth   = LevelWidth + VolWidth + 1;
   localparam int MulPWidth   = MulAWidth + MulBWidth;

   // configuration port
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   // reset values of the configuration registers
   localparam logic [VolWidth-1:0] MasterVolReset = 9'd256;
   localparam logic [VolWidth-1:0] VoiceVolReset  = 9'd256;
   localparam logic                ByteOutReset   = 1'b0;
   localparam logic                StereoOutReset = 1'b1;

   // default output ring size in words
   localparam int RingWordsDefault = 16384;

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic        [LevelWidth-1:0]  level_type;
   typedef logic        [VolWidth-1:0]    vol_type;
   typedef logic signed [RawWidth-1:0]    raw_type;
   typedef logic signed [AccWidth-1:0]    acc_type;
   typedef logic signed [OutWidth-1:0]    out_type;
   typedef logic        [ByteWidth-1:0]   byte_type;
   typedef logic        [PosWidth-1:0]    pos_type;

   // register index codes (byte address / 4)
   typedef enum logic [1:0] {
      REG_MASTER_VOL = 2'd0,
      REG_VOICE_VOL  = 2'd1,
      REG_BYTE_OUT   = 2'd2,
      REG_STEREO_OUT = 2'd3
   } reg_idx_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LVL_L,
      ST_SMP_L,
      ST_LVL_R,
      ST_SMP_R,
      ST_ADD_R,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/core/mvmix_if.sv -----
// item channels of the mixer: voice request and frame response
interface mvmix_req_if;
   import mvmix_pkg::*;

   logic       valid;
   logic       ready;
   sample_type voice_sample;
   level_type  left_level;
   level_type  right_level;
   logic       voice_class;
   logic       first_of_frame;
   logic       raw_valid;
   raw_type    raw_left;
   raw_type    raw_right;
   logic       last_of_frame;

   modport source (
      output valid, voice_sample, left_level, right_level, voice_class,
             first_of_frame, raw_valid, raw_left, raw_right, last_of_frame,
      input  ready
   );
   modport sink (
      input  valid, voice_sample, left_level, right_level, voice_class,
             first_of_frame, raw_valid, raw_left, raw_right, last_of_frame,
      output ready
   );
endinterface

interface mvmix_rsp_if;
   import mvmix_pkg::*;

   logic      valid;
   logic      ready;
   out_type   out_left;
   out_type   out_right;
   byte_type  out_left_byte;
   byte_type  out_right_byte;
   pos_type   ring_index;

   modport source (
      output valid, out_left, out_right, out_left_byte, out_right_byte, ring_index,
      input  ready
   );
   modport sink (
      input  valid, out_left, out_right, out_left_byte, out_right_byte, ring_index,
      output ready
   );
endinterface

// ----- rtl/core/multivoice_audio_mix_clip.sv -----
// stereo voice mixer top level: one shared multiplier under a small sequencer
// sequencing: an accepted item runs through the LVL_L, SMP_L, LVL_R, SMP_R and ADD_R
//   states; an item that closes a frame then waits in ST_EMIT to load the result register
// a new item is taken only in ST_IDLE, once the last one is through; the single 17x18
//   multiplier runs four products per item (two level*volume, two sample*gain) back to back
// reset: synchronous, active high; volumes 256, stereo on, byte mode off,
//   accumulators, frame position and ring indices zero, no result pending
module multivoice_audio_mix_clip #(
   parameter int RING_WORDS = mvmix_pkg::RingWordsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   mvmix_req_if.sink                             req_chan,
   mvmix_rsp_if.source                           rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mvmix_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [mvmix_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [mvmix_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import mvmix_pkg::*;

   localparam int IdxWidth = $clog2(RING_WORDS);
   localparam logic [IdxWidth:0] RingLimit = (IdxWidth+1)'(RING_WORDS);
   localparam logic [IdxWidth:0] StepOne   = (IdxWidth+1)'(1);
   localparam logic [IdxWidth:0] StepTwo   = (IdxWidth+1)'(2);
   localparam pos_type           PosLast   = {PosWidth{1'b1}};

   // shift right by 8 and clip to 16-bit signed
   function automatic out_type clip16(input acc_type acc);
      logic signed [AccWidth-9:0] shifted;
      shifted = acc[AccWidth-1:8];
      if (shifted[AccWidth-9:OutWidth-1] == '0 ||
          shifted[AccWidth-9:OutWidth-1] == '1) begin
         clip16 = shifted[OutWidth-1:0];
      end else if (shifted[AccWidth-9]) begin
         clip16 = {1'b1, {(OutWidth-1){1'b0}}};
      end else begin
         clip16 = {1'b0, {(OutWidth-1){1'b1}}};
      end
   endfunction

   // configuration registers
   vol_type master_vol_ff, master_vol_in;
   vol_type vox_vol_ff, vox_vol_in;
   logic    byte_out_ff, byte_out_in;
   logic    stereo_out_ff, stereo_out_in;

   // sequencer and latched item
   state_type  state_ff, state_in;
   sample_type sample_ff, sample_in;
   level_type  lvl_l_ff, lvl_l_in;
   level_type  lvl_r_ff, lvl_r_in;
   vol_type    vol_ff, vol_in;
   logic       last_ff, last_in;

   // datapath
   logic signed [MulPWidth-1:0] prod_ff, prod_in;
   acc_type left_acc_ff, left_acc_in;
   acc_type right_acc_ff, right_acc_in;
   pos_type pos_ff, pos_in;
   logic [IdxWidth-1:0] idx1_ff, idx1_in;
   logic [IdxWidth-1:0] idx2_ff, idx2_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   out_type  out_left_ff, out_left_in;
   out_type  out_right_ff, out_right_in;
   byte_type out_left_byte_ff, out_left_byte_in;
   byte_type out_right_byte_ff, out_right_byte_in;
   pos_type  ring_index_ff, ring_index_in;

   // combinational helpers
   logic                        accept;
   logic                        csr_write;
   logic                        out_free;
   logic signed [MulAWidth-1:0] mul_a;
   logic signed [MulBWidth-1:0] mul_b;
   logic signed [MulPWidth-1:0] mul_res;
   acc_type                     add_base;
   logic signed [AccWidth+1:0]  add_sum;
   acc_type                     add_sat;
   logic [IdxWidth:0]           idx1_step;
   logic [IdxWidth:0]           idx2_step;
   out_type                     clip_l;
   out_type                     clip_r;
   reg_idx_type                 csr_idx;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign csr_pready     = 1'b1;
   assign csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx        = reg_idx_type'(csr_paddr[3:2]);

   // register read mux
   always_comb begin
      case (csr_idx)
         REG_MASTER_VOL: csr_prdata = CsrDataWidth'(master_vol_ff);
         REG_VOICE_VOL:  csr_prdata = CsrDataWidth'(vox_vol_ff);
         REG_BYTE_OUT:   csr_prdata = CsrDataWidth'(byte_out_ff);
         REG_STEREO_OUT: csr_prdata = CsrDataWidth'(stereo_out_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // register writes
   always_comb begin
      master_vol_in = master_vol_ff;
      vox_vol_in    = vox_vol_ff;
      byte_out_in   = byte_out_ff;
      stereo_out_in = stereo_out_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_MASTER_VOL: master_vol_in = csr_pwdata[VolWidth-1:0];
            REG_VOICE_VOL:  vox_vol_in    = csr_pwdata[VolWidth-1:0];
            REG_BYTE_OUT:   byte_out_in   = csr_pwdata[0];
            REG_STEREO_OUT: stereo_out_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // shared multiplier: level*volume, then sample*gain
   always_comb begin
      if (state_ff == ST_SMP_L || state_ff == ST_SMP_R) begin
         mul_a = {sample_ff[SampleWidth-1], sample_ff};
         mul_b = {1'b0, prod_ff[LevelWidth+VolWidth-1:0]};
      end else begin
         mul_a = {{(MulAWidth-LevelWidth){1'b0}},
                  (state_ff == ST_LVL_R) ? lvl_r_ff : lvl_l_ff};
         mul_b = {{(MulBWidth-VolWidth){1'b0}}, vol_ff};
      end
   end
   assign mul_res = MulPWidth'(mul_a) * MulPWidth'(mul_b);

   // shared saturating accumulate of the product shifted right by 8
   always_comb begin
      add_base = (state_ff == ST_ADD_R) ? right_acc_ff : left_acc_ff;
      add_sum  = (AccWidth+2)'(add_base)
                 + (AccWidth+2)'($signed(prod_ff[MulPWidth-1:8]));
      if (add_sum[AccWidth+1:AccWidth-1] == '0 || add_sum[AccWidth+1:AccWidth-1] == '1) begin
         add_sat = add_sum[AccWidth-1:0];
      end else if (add_sum[AccWidth+1]) begin
         add_sat = {1'b1, {(AccWidth-1){1'b0}}};
      end else begin
         add_sat = {1'b0, {(AccWidth-1){1'b1}}};
      end
   end

   // ring index stepping, mono and stereo kept side by side
   always_comb begin
      idx1_step = {1'b0, idx1_ff} + StepOne;
      if (idx1_step >= RingLimit) begin
         idx1_step = idx1_step - RingLimit;
      end
      idx2_step = {1'b0, idx2_ff} + StepTwo;
      if (idx2_step >= RingLimit) begin
         idx2_step = idx2_step - RingLimit;
      end
   end

   assign clip_l = clip16(left_acc_ff);
   assign clip_r = clip16(right_acc_ff);

   // sequencer next state and datapath updates
   always_comb begin
      state_in          = state_ff;
      sample_in         = sample_ff;
      lvl_l_in          = lvl_l_ff;
      lvl_r_in          = lvl_r_ff;
      vol_in            = vol_ff;
      last_in           = last_ff;
      prod_in           = mul_res;
      left_acc_in       = left_acc_ff;
      right_acc_in      = right_acc_ff;
      pos_in            = pos_ff;
      idx1_in           = idx1_ff;
      idx2_in           = idx2_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      out_left_in       = out_left_ff;
      out_right_in      = out_right_ff;
      out_left_byte_in  = out_left_byte_ff;
      out_right_byte_in = out_right_byte_ff;
      ring_index_in     = ring_index_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_chan.voice_sample;
               lvl_l_in  = req_chan.left_level;
               lvl_r_in  = req_chan.right_level;
               vol_in    = req_chan.voice_class ? vox_vol_ff : master_vol_ff;
               last_in   = req_chan.last_of_frame;
               // frame start: load the background pair or silence
               if (req_chan.first_of_frame) begin
                  left_acc_in  = req_chan.raw_valid ? AccWidth'(req_chan.raw_left) : '0;
                  right_acc_in = req_chan.raw_valid ? AccWidth'(req_chan.raw_right) : '0;
               end
               state_in = ST_LVL_L;
            end
         end
         ST_LVL_L: state_in = ST_SMP_L;
         ST_SMP_L: state_in = ST_LVL_R;
         ST_LVL_R: begin
            left_acc_in = add_sat;
            state_in    = ST_SMP_R;
         end
         ST_SMP_R: state_in = ST_ADD_R;
         ST_ADD_R: begin
            right_acc_in = add_sat;
            state_in     = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // wait for the result register to free up
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               out_left_in      = clip_l;
               out_left_byte_in = clip_l[OutWidth-1:OutWidth-ByteWidth] ^ 8'h80;
               if (stereo_out_ff) begin
                  out_right_in      = clip_r;
                  out_right_byte_in = clip_r[OutWidth-1:OutWidth-ByteWidth] ^ 8'h80;
                  ring_index_in     = PosWidth'(idx2_ff);
               end else begin
                  out_right_in      = '0;
                  out_right_byte_in = 8'h80;
                  ring_index_in     = PosWidth'(idx1_ff);
               end
               pos_in = pos_ff + PosWidth'(1);
               if (pos_ff == PosLast) begin
                  idx1_in = '0;
                  idx2_in = '0;
               end else begin
                  idx1_in = idx1_step[IdxWidth-1:0];
                  idx2_in = idx2_step[IdxWidth-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         master_vol_ff <= MasterVolReset;
         vox_vol_ff    <= VoiceVolReset;
         byte_out_ff   <= ByteOutReset;
         stereo_out_ff <= StereoOutReset;
         left_acc_ff   <= '0;
         right_acc_ff  <= '0;
         pos_ff        <= '0;
         idx1_ff       <= '0;
         idx2_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         master_vol_ff <= master_vol_in;
         vox_vol_ff    <= vox_vol_in;
         byte_out_ff   <= byte_out_in;
         stereo_out_ff <= stereo_out_in;
         left_acc_ff   <= left_acc_in;
         right_acc_ff  <= right_acc_in;
         pos_ff        <= pos_in;
         idx1_ff       <= idx1_in;
         idx2_ff       <= idx2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff         <= sample_in;
      lvl_l_ff          <= lvl_l_in;
      lvl_r_ff          <= lvl_r_in;
      vol_ff            <= vol_in;
      last_ff           <= last_in;
      prod_ff           <= prod_in;
      out_left_ff       <= out_left_in;
      out_right_ff      <= out_right_in;
      out_left_byte_ff  <= out_left_byte_in;
      out_right_byte_ff <= out_right_byte_in;
      ring_index_ff     <= ring_index_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_left       = out_left_ff;
   assign rsp_chan.out_right      = out_right_ff;
   assign rsp_chan.out_left_byte  = out_left_byte_ff;
   assign rsp_chan.out_right_byte = out_right_byte_ff;
   assign rsp_chan.ring_index     = ring_index_ff;

`ifndef ASSERT_OFF
   // an accepted item keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_chan.ready)
      else $error("ready right after accepting an item");

   // a new result only comes out of the emit step
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit step");

   // accumulators hold while idle and no item arrives
   a_acc_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |=>
         ($stable(left_acc_ff) && $stable(right_acc_ff)))
      else $error("accumulator changed while idle");

   // ring indices stay inside the ring
   a_idx_in_ring: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, idx1_ff} < RingLimit) && ({1'b0, idx2_ff} < RingLimit))
      else $error("ring index out of range");

   // frame position steps by one per emitted frame
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (pos_ff == $past(pos_ff) + PosWidth'(1)))
      else $error("frame position did not step");
`endif

endmodule

// ----- tb/tb.sv -----
// testbench for the multivoice mixer: directed and random voice traffic against a predictor
`timescale 1ns / 100ps

module tb;
   import mvmix_pkg::*;

   localparam int     DrainCycles = 12;
   localparam int     StallLimit  = 3000;
   localparam int     SatVoices   = 132;
   localparam longint RingWordsTb = RingWordsDefault;

   // one voice item as sent on the request channel
   typedef struct {
      sample_type sample;
      level_type  lvl_l;
      level_type  lvl_r;
      logic       vclass;
      logic       opens;
      logic       raw_ok;
      raw_type    raw_l;
      raw_type    raw_r;
      logic       closes;
   } voice_item_type;

   // one mixed frame as expected on the response channel
   typedef struct {
      out_type  left;
      out_type  right;
      byte_type left_byte;
      byte_type right_byte;
      pos_type  ring;
   } mix_frame_type;

   logic clock;
   logic reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   mvmix_req_if voice_bus ();
   mvmix_rsp_if frame_bus ();

   multivoice_audio_mix_clip DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (voice_bus),
      .rsp_chan    (frame_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // mixer copy: registers, accumulators and frame position
   vol_type       master_vol;
   vol_type       vox_vol;
   logic          byte_mode;
   logic          stereo_mode;
   longint        mix_acc_l;
   longint        mix_acc_r;
   pos_type       frame_pos;
   mix_frame_type pending_frames[$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int items_sent;
   int frames_checked;
   int stall_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accumulator add saturates to the signed 32-bit range
   function automatic longint sat_to_acc(input longint x);
      longint acc_max;
      longint acc_min;
      acc_max = (longint'(1) <<< 31) - 1;
      acc_min = -(longint'(1) <<< 31);
      if (x > acc_max) return acc_max;
      if (x < acc_min) return acc_min;
      return x;
   endfunction

   // drop 8 fraction bits, then clip to 16-bit signed
   function automatic out_type clip_to_out(input longint acc);
      longint v;
      v = acc >>> 8;
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return out_type'(v);
   endfunction

   // unsigned 8-bit form: high byte plus 128
   function automatic byte_type to_byte_form(input out_type c);
      return byte_type'((longint'(c) >>> 8) + 128);
   endfunction

   // mix one accepted voice and queue the frame it closes, if any
   function automatic void mix_voice(input voice_item_type v);
      longint        vol;
      longint        gain_l;
      longint        gain_r;
      mix_frame_type f;
      vol = v.vclass ? longint'(vox_vol) : longint'(master_vol);
      if (v.opens) begin
         mix_acc_l = v.raw_ok ? longint'(v.raw_l) : 0;
         mix_acc_r = v.raw_ok ? longint'(v.raw_r) : 0;
      end
      gain_l = longint'(v.lvl_l) * vol;
      gain_r = longint'(v.lvl_r) * vol;
      mix_acc_l = sat_to_acc(mix_acc_l + ((longint'(v.sample) * gain_l) >>> 8));
      mix_acc_r = sat_to_acc(mix_acc_r + ((longint'(v.sample) * gain_r) >>> 8));
      if (v.closes) begin
         f.left      = clip_to_out(mix_acc_l);
         f.left_byte = to_byte_form(f.left);
         if (stereo_mode) begin
            f.right      = clip_to_out(mix_acc_r);
            f.right_byte = to_byte_form(f.right);
         end else begin
            f.right      = '0;
            f.right_byte = 8'd128;
         end
         f.ring = pos_type'((longint'(frame_pos) * (stereo_mode ? 2 : 1)) % RingWordsTb);
         frame_pos = frame_pos + 1'b1;
         pending_frames.push_back(f);
      end
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // compare each mixed frame against the oldest expectation
   always @(posedge clock) begin : check_frames
      mix_frame_type want;
      if (!reset && frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected frame: left %0d right %0d ring %0d",
                   frame_bus.out_left, frame_bus.out_right, frame_bus.ring_index);
            mismatches++;
         end else begin
            want = pending_frames.pop_front();
            check_field("out_left", want.left, frame_bus.out_left);
            check_field("out_right", want.right, frame_bus.out_right);
            check_field("out_left_byte", want.left_byte, frame_bus.out_left_byte);
            check_field("out_right_byte", want.right_byte, frame_bus.out_right_byte);
            check_field("ring_index", want.ring, frame_bus.ring_index);
            frames_checked++;
         end
      end
   end

   // frame receiver with random back-pressure
   always @(negedge clock) begin
      frame_bus.ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if ((voice_bus.valid === 1'b1 && voice_bus.ready === 1'b1) ||
          (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("multivoice_audio_mix_clip verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one register access: setup cycle, access cycle, then the bus returns to idle
   task automatic csr_access(input reg_idx_type idx, input logic wr,
                             input logic [CsrDataWidth-1:0] wdata,
                             output logic [CsrDataWidth-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_register(input reg_idx_type idx, input int unsigned want);
      logic [CsrDataWidth-1:0] got;
      csr_access(idx, 1'b0, '0, got);
      check_field($sformatf("register %s", idx.name()), want, got);
   endtask

   task automatic set_register(input reg_idx_type idx, input int unsigned value);
      logic [CsrDataWidth-1:0] ignored;
      csr_access(idx, 1'b1, value, ignored);
      case (idx)
         REG_MASTER_VOL: master_vol = vol_type'(value);
         REG_VOICE_VOL:  vox_vol = vol_type'(value);
         REG_BYTE_OUT:   byte_mode = value[0];
         REG_STEREO_OUT: stereo_mode = value[0];
         default: begin
         end
      endcase
      check_register(idx, value);
   endtask

   // hold off the sender until every expected frame is back
   task automatic wait_frames_drained();
      voice_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_frames.size() != 0);
   endtask

   task automatic set_mixer(input int unsigned mvol, input int unsigned vvol,
                            input int unsigned bmode, input int unsigned smode);
      wait_frames_drained();
      repeat (DrainCycles) @(negedge clock);
      set_register(REG_MASTER_VOL, mvol);
      set_register(REG_VOICE_VOL, vvol);
      set_register(REG_BYTE_OUT, bmode);
      set_register(REG_STEREO_OUT, smode);
   endtask

   // send one voice item, predicting at acceptance
   task automatic send_voice(input voice_item_type v);
      while (int'($urandom_range(0, 99)) < send_idle_pct) begin
         voice_bus.valid <= 1'b0;
         @(negedge clock);
      end
      voice_bus.voice_sample   <= v.sample;
      voice_bus.left_level     <= v.lvl_l;
      voice_bus.right_level    <= v.lvl_r;
      voice_bus.voice_class    <= v.vclass;
      voice_bus.first_of_frame <= v.opens;
      voice_bus.raw_valid      <= v.raw_ok;
      voice_bus.raw_left       <= v.raw_l;
      voice_bus.raw_right      <= v.raw_r;
      voice_bus.last_of_frame  <= v.closes;
      voice_bus.valid          <= 1'b1;
      @(posedge clock);
      while (voice_bus.ready !== 1'b1) @(posedge clock);
      mix_voice(v);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic voice_item_type make_voice(input int smp, input int ll, input int lr,
                                                 input bit cls, input bit opens,
                                                 input bit raw_ok, input int rl, input int rr,
                                                 input bit closes);
      voice_item_type v;
      v.sample = sample_type'(smp);
      v.lvl_l  = level_type'(ll);
      v.lvl_r  = level_type'(lr);
      v.vclass = cls;
      v.opens  = opens;
      v.raw_ok = raw_ok;
      v.raw_l  = raw_type'(rl);
      v.raw_r  = raw_type'(rr);
      v.closes = closes;
      return v;
   endfunction

   function automatic int pick_sample();
      case ($urandom_range(0, 9))
         0:       return 32767;
         1:       return -32768;
         2:       return 0;
         3, 4, 5: return $signed($urandom_range(0, 1023)) - 512;
         default: return int'(sample_type'($urandom));
      endcase
   endfunction

   function automatic int pick_level();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic int pick_raw();
      case ($urandom_range(0, 5))
         0:       return 8388607;
         1:       return -8388608;
         2, 3:    return $signed($urandom_range(0, 65535)) - 32768;
         default: return int'(raw_type'($urandom));
      endcase
   endfunction

   function automatic voice_item_type random_voice(input bit opens, input bit closes);
      return make_voice(pick_sample(), pick_level(), pick_level(), 1'($urandom_range(0, 1)),
                        opens, 1'($urandom_range(0, 1)), pick_raw(), pick_raw(), closes);
   endfunction

   // register values after reset
   task automatic test_register_reset();
      check_register(REG_MASTER_VOL, MasterVolReset);
      check_register(REG_VOICE_VOL, VoiceVolReset);
      check_register(REG_BYTE_OUT, ByteOutReset);
      check_register(REG_STEREO_OUT, StereoOutReset);
   endtask

   // field extremes, background pair, open frames and single-item frames
   task automatic test_directed_frames();
      send_voice(make_voice(32767, 255, 255, 0, 1, 0, 0, 0, 1));
      send_voice(make_voice(-32768, 255, 0, 1, 1, 0, 0, 0, 1));
      send_voice(make_voice(0, 255, 255, 0, 1, 1, 8388607, -8388608, 1));
      send_voice(make_voice(1000, 128, 128, 1, 1, 0, 8388607, -8388608, 1));
      send_voice(make_voice(-1, 3, 1, 0, 1, 1, -1, 255, 1));
      // three-voice frame on top of a background pair
      send_voice(make_voice(123, 10, 200, 0, 1, 1, 40000, -40000, 0));
      send_voice(make_voice(-4567, 90, 17, 1, 0, 0, 0, 0, 0));
      send_voice(make_voice(32767, 1, 1, 0, 0, 0, 0, 0, 1));
      // keep adding without reloading the accumulators
      send_voice(make_voice(-20000, 64, 32, 0, 0, 1, 8388607, 8388607, 1));
      send_voice(make_voice(5, 0, 0, 1, 0, 0, 0, 0, 0));
      send_voice(make_voice(-32768, 200, 255, 1, 0, 0, 0, 0, 1));
   endtask

   // volume registers at their extremes and rounding toward minus infinity
   task automatic test_volume_extremes();
      set_mixer(0, 511, 0, 1);
      send_voice(make_voice(32767, 255, 255, 0, 1, 1, 1000, -1000, 0));
      send_voice(make_voice(-32768, 255, 128, 1, 0, 0, 0, 0, 1));
      set_mixer(511, 0, 0, 1);
      send_voice(make_voice(-32768, 255, 255, 1, 1, 0, 0, 0, 0));
      send_voice(make_voice(12345, 77, 255, 0, 0, 0, 0, 0, 1));
      set_mixer(1, 3, 0, 1);
      send_voice(make_voice(-1, 1, 1, 0, 1, 0, 0, 0, 0));
      send_voice(make_voice(-1, 1, 255, 1, 0, 0, 0, 0, 0));
      send_voice(make_voice(-1, 255, 1, 0, 0, 0, 0, 0, 1));
   endtask

   // mono ring and byte mode
   task automatic test_mono_byte_mode();
      set_mixer(256, 256, 1, 0);
      send_voice(make_voice(30000, 255, 255, 0, 1, 0, 0, 0, 1));
      send_voice(make_voice(-30000, 100, 255, 1, 1, 1, -300000, 300000, 1));
      set_mixer(300, 200, 0, 0);
      send_voice(make_voice(-7, 9, 250, 0, 1, 0, 0, 0, 1));
      send_voice(make_voice(32767, 255, 0, 1, 1, 1, 8388607, 0, 1));
   endtask

   // long frames that drive the accumulators into saturation
   task automatic test_accumulator_saturation();
      set_mixer(511, 511, 0, 1);
      for (int k = 0; k < SatVoices; k++)
         send_voice(make_voice(32767, 255, 255, 1'(k % 2), k == 0, 1, 8388607, 8388607,
                               k == SatVoices - 1));
      for (int k = 0; k < SatVoices; k++)
         send_voice(make_voice(-32768, 255, 255, 1'(k % 2), k == 0, 1, -8388608, -8388608,
                               k == SatVoices - 1));
   endtask

   // mostly well-formed random frames, some items with random frame flags
   task automatic run_random_mix(input int n_items);
      int sent;
      int len;
      int k;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            send_voice(random_voice(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            sent++;
         end else begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
               send_voice(random_voice(k == 0, k == len - 1));
               sent++;
            end
         end
         if ($urandom_range(0, 29) == 0) wait_frames_drained();
      end
   endtask

   // random traffic across the three idle patterns and several register settings
   task automatic test_random_traffic();
      send_idle_pct = 13;
      recv_idle_pct = 53;
      set_mixer($urandom_range(0, 511), $urandom_range(0, 511), 0, 1);
      run_random_mix(110);
      set_mixer(511, 0, 1, 0);
      run_random_mix(50);
      send_idle_pct = 53;
      recv_idle_pct = 13;
      set_mixer(0, 511, 0, 1);
      run_random_mix(50);
      set_mixer($urandom_range(0, 511), $urandom_range(0, 511), 1, 0);
      run_random_mix(80);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_mixer($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1), 1);
      run_random_mix(110);
      set_mixer(MasterVolReset, VoiceVolReset, ByteOutReset, StereoOutReset);
      run_random_mix(50);
   endtask

   // reset, tests in turn, drain and verdict
   initial begin
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      voice_bus.valid          = 1'b0;
      voice_bus.voice_sample   = '0;
      voice_bus.left_level     = '0;
      voice_bus.right_level    = '0;
      voice_bus.voice_class    = 1'b0;
      voice_bus.first_of_frame = 1'b0;
      voice_bus.raw_valid      = 1'b0;
      voice_bus.raw_left       = '0;
      voice_bus.raw_right      = '0;
      voice_bus.last_of_frame  = 1'b0;
      frame_bus.ready          = 1'b0;
      master_vol     = MasterVolReset;
      vox_vol        = VoiceVolReset;
      byte_mode      = ByteOutReset;
      stereo_mode    = StereoOutReset;
      mix_acc_l      = 0;
      mix_acc_r      = 0;
      frame_pos      = '0;
      mismatches     = 0;
      items_sent     = 0;
      frames_checked = 0;
      stall_cycles   = 0;
      send_idle_pct  = 13;
      recv_idle_pct  = 53;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_reset();
      test_directed_frames();
      test_volume_extremes();
      test_mono_byte_mode();
      test_accumulator_saturation();
      test_random_traffic();

      wait_frames_drained();
      repeat (DrainCycles) @(negedge clock);
      $display("run covered %0d voice items and %0d mixed frames", items_sent, frames_checked);
      $display("stereo and mono, byte mode, volumes 0 to 511, saturation, three idle patterns");
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("multivoice_audio_mix_clip verification clean");
      end else begin
         $display("multivoice_audio_mix_clip verification failed");
      end
      $finish;
   end

endmodule
